// ----- rtl/hdu_pkg.sv -----
package hdu_pkg;

  // Division of the scaled angle by 45, one base-256 quotient digit per
  // stage: the digit comes from a reciprocal multiply of the partial
  // remainder, exact for every partial remainder below 45 * 256.
  localparam int DIV_W = 48;
  localparam int DIV_PER_STAGE = 8;
  localparam int DIV_STAGES = DIV_W / DIV_PER_STAGE;
  localparam int DIV_LANES = 4;
  localparam int DIV_PART_W = 6 + DIV_PER_STAGE;
  localparam logic [6:0] DIV_BY = 7'd45;
  localparam logic [DIV_PART_W-1:0] DIV_RECIP = 14'd11651;
  localparam int DIV_RECIP_SHIFT = 19;
  localparam logic signed [DIV_W-1:0] DIV_OFFSET = 48'sd45 <<< 40;
  localparam logic signed [DIV_W-1:0] DIV_ROUND = 48'sd22;

  // Rotation and vectoring iterations.
  localparam int CORD_STEPS = 30;
  localparam int CORD_PER_STAGE = 2;
  localparam int CORD_STAGES = CORD_STEPS / CORD_PER_STAGE;
  localparam int XY_W = 33;
  localparam int Z_W = 34;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [Z_W-1:0] HALF_TURN = 34'sh0_8000_0000;
  localparam int ROT_LANES = 4;
  // Lanes that deliver the sine; the others deliver the cosine.
  localparam logic [ROT_LANES-1:0] ROT_SIN_LANES = 4'b0011;

  // Square roots, two root bits per stage.
  localparam int SQ_STEPS = 32;
  localparam int SQ_PER_STAGE = 2;
  localparam int SQ_STAGES = SQ_STEPS / SQ_PER_STAGE;
  localparam int SQ_LANES = 2;
  localparam int SQ_N_W = 2 * SQ_STEPS;
  localparam int SQ_REM_W = 35;
  localparam int A_W = 31;
  localparam logic [A_W-1:0] ONE_A = 31'h4000_0000;

  localparam logic [31:0] KM_PER_TURN_Q16 = 32'd2623417457;
  localparam logic [30:0] MAX_DIST = 31'd1311708729;

  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/haversine_distance_unit.sv -----
// Haversine great-circle distance on a 6371 km sphere. Each transfer on the
// pair channel carries two positions in signed degrees with 23 fraction bits;
// each transfer on the dist channel returns the distance in km with 16
// fraction bits, one result per pair, in order. The pipeline takes one pair
// every cycle while pair_stall is low; each pair passes one input stage,
// six stages of angle scaling (divide by 45, eight quotient bits a stage),
// seventeen stages of sine/cosine rotation (two iterations in each rotating
// stage), three stages of products and clamping, sixteen stages of square
// root (two root bits a stage), sixteen stages of atan2 vectoring, one
// scaling multiply and the output register. A skid register behind the
// pipeline holds one result while dist_stall is high; the whole pipeline
// holds only when that skid register is full, and pair_stall is then high.
// Positions out of range are used as given and angles wrap modulo a turn.
module haversine_distance_unit (
  input  logic clk,
  input  logic rst,
  input  logic pair_valid,
  output logic pair_stall,
  input  logic signed [30:0] from_latitude,
  input  logic signed [31:0] from_longitude,
  input  logic signed [30:0] to_latitude,
  input  logic signed [31:0] to_longitude,
  output logic dist_valid,
  input  logic dist_stall,
  output logic [30:0] distance_km
);
  import hdu_pkg::*;

  logic en;
  logic out_free;

  // input stage: scaled angles ready for the divide by 45
  logic v_in;
  logic [DIV_W-1:0] num [DIV_LANES];
  logic [DIV_W-1:0] num_next [DIV_LANES];

  logic v_div;
  logic [31:0] ang [DIV_LANES];
  logic v_rot;
  logic signed [XY_W-1:0] rot [ROT_LANES];

  // product stages
  logic v_p1, v_p2, v_c;
  logic signed [XY_W-1:0] hlat, hlon, pcos, hlat2, hlonp;
  logic [A_W-1:0] rad [SQ_LANES];

  logic v_sq;
  logic [A_W-1:0] root [SQ_LANES];
  logic v_vec;
  logic [31:0] cturn;

  // scale stage and output side
  logic v_s;
  logic [30:0] dist_s;
  logic skid_v;
  logic [30:0] skid_d;

  assign en = !skid_v;
  assign pair_stall = skid_v;
  assign out_free = !dist_valid || !dist_stall;

  always_comb begin
    logic signed [DIV_W-1:0] e;
    // half differences: d * 32 / 45; latitudes: L * 64 / 45
    e = DIV_W'(to_latitude) - DIV_W'(from_latitude);
    num_next[0] = (e <<< 5) + DIV_ROUND + DIV_OFFSET;
    e = DIV_W'(to_longitude) - DIV_W'(from_longitude);
    num_next[1] = (e <<< 5) + DIV_ROUND + DIV_OFFSET;
    e = DIV_W'(from_latitude);
    num_next[2] = (e <<< 6) + DIV_ROUND + DIV_OFFSET;
    e = DIV_W'(to_latitude);
    num_next[3] = (e <<< 6) + DIV_ROUND + DIV_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_next;
    end
  end

  hdu_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_v(v_in), .num(num),
    .out_v(v_div), .quo(ang)
  );

  hdu_rotate u_rot (
    .clk(clk), .rst(rst), .en(en), .in_v(v_div), .ang(ang),
    .out_v(v_rot), .res(rot)
  );

  // lanes: sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2)
  always_ff @(posedge clk) begin
    logic signed [2*XY_W-1:0] m;
    logic signed [XY_W:0] sum;
    if (en) begin
      m = (2*XY_W)'(rot[0]) * (2*XY_W)'(rot[0]);
      hlat <= XY_W'(m >>> 30);
      m = (2*XY_W)'(rot[1]) * (2*XY_W)'(rot[1]);
      hlon <= XY_W'(m >>> 30);
      m = (2*XY_W)'(rot[2]) * (2*XY_W)'(rot[3]);
      pcos <= XY_W'(m >>> 30);

      hlat2 <= hlat;
      m = (2*XY_W)'(hlon) * (2*XY_W)'(pcos);
      hlonp <= XY_W'(m >>> 30);

      // clamp the haversine term to 0..1
      sum = (XY_W+1)'(hlat2) + (XY_W+1)'(hlonp);
      if (sum < 0) begin
        sum = '0;
      end else if (sum > (XY_W+1)'(ONE_A)) begin
        sum = (XY_W+1)'(ONE_A);
      end
      rad[0] <= sum[A_W-1:0];
      rad[1] <= ONE_A - sum[A_W-1:0];
    end
  end

  hdu_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_v(v_c), .rad(rad),
    .out_v(v_sq), .root(root)
  );

  hdu_vector u_vec (
    .clk(clk), .rst(rst), .en(en), .in_v(v_sq), .xin(root[1]), .yin(root[0]),
    .out_v(v_vec), .cturn(cturn)
  );

  always_ff @(posedge clk) begin
    logic [63:0] pr;
    if (en) begin
      pr = 64'(cturn) * 64'(KM_PER_TURN_Q16) + 64'h8000_0000;
      dist_s <= pr[62:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
      v_p1 <= 1'b0;
      v_p2 <= 1'b0;
      v_c <= 1'b0;
      v_s <= 1'b0;
    end else if (en) begin
      v_in <= pair_valid;
      v_p1 <= v_rot;
      v_p2 <= v_p1;
      v_c <= v_p2;
      v_s <= v_vec;
    end
  end

  // Output register plus skid: drain the skid first; while it is full hold
  // the pipeline, otherwise advance and park the leaving result if stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_free) begin
        dist_valid <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (out_free) begin
      dist_valid <= v_s;
    end else if (v_s) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_free) begin
        distance_km <= skid_d;
      end
    end else if (out_free) begin
      distance_km <= dist_s;
    end else begin
      skid_d <= dist_s;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> dist_valid)
    else $error("skid holds a result while the output register is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(dist_valid && dist_stall && v_s))
    else $error("skid filled without a stalled output");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> distance_km <= MAX_DIST)
    else $error("distance above half the circumference");
`endif

endmodule

// ----- rtl/hdu_div.sv -----
module hdu_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic [hdu_pkg::DIV_W-1:0] num [hdu_pkg::DIV_LANES],
  output logic out_v,
  output logic [31:0] quo [hdu_pkg::DIV_LANES]
);
  import hdu_pkg::*;

  logic [DIV_STAGES-1:0] v;
  logic [DIV_W-1:0] num_r [DIV_STAGES][DIV_LANES];
  logic [5:0] rem_r [DIV_STAGES][DIV_LANES];
  logic [31:0] quo_r [DIV_STAGES][DIV_LANES];
  logic [DIV_W-1:0] num_next [DIV_STAGES][DIV_LANES];
  logic [5:0] rem_next [DIV_STAGES][DIV_LANES];
  logic [31:0] quo_next [DIV_STAGES][DIV_LANES];

  always_comb begin
    logic [DIV_W-1:0] n;
    logic [5:0] r;
    logic [DIV_PART_W-1:0] part, dig, back;
    logic [2*DIV_PART_W-1:0] prod;
    logic [DIV_PER_STAGE-1:0] qd;
    logic [31:0] q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        if (s == 0) begin
          n = num[l];
          r = '0;
          q = '0;
        end else begin
          n = num_r[s-1][l];
          r = rem_r[s-1][l];
          q = quo_r[s-1][l];
        end
        // bring down the next byte, take its digit by reciprocal multiply
        part = {r, n[DIV_W-1 -: DIV_PER_STAGE]};
        n = {n[DIV_W-DIV_PER_STAGE-1:0], DIV_PER_STAGE'(0)};
        prod = part * DIV_RECIP;
        qd = prod[DIV_RECIP_SHIFT +: DIV_PER_STAGE];
        dig = DIV_PART_W'(qd);
        back = part - dig * DIV_PART_W'(DIV_BY);
        r = back[5:0];
        q = {q[31-DIV_PER_STAGE:0], qd};
        num_next[s][l] = n;
        rem_next[s][l] = r;
        quo_next[s][l] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DIV_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_next;
      rem_r <= rem_next;
      quo_r <= quo_next;
    end
  end

  assign out_v = v[DIV_STAGES-1];
  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ----- rtl/hdu_rotate.sv -----
module hdu_rotate (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic [31:0] ang [hdu_pkg::ROT_LANES],
  output logic out_v,
  output logic signed [hdu_pkg::XY_W-1:0] res [hdu_pkg::ROT_LANES]
);
  import hdu_pkg::*;

  // Stage 0 folds the angle, stages 1..CORD_STAGES rotate, one more negates.
  logic [CORD_STAGES+1:0] v;
  logic signed [XY_W-1:0] x_r [CORD_STAGES+1][ROT_LANES];
  logic signed [XY_W-1:0] y_r [CORD_STAGES+1][ROT_LANES];
  logic signed [Z_W-1:0] z_r [CORD_STAGES+1][ROT_LANES];
  logic neg_r [CORD_STAGES+1][ROT_LANES];
  logic signed [XY_W-1:0] x_next [CORD_STAGES+1][ROT_LANES];
  logic signed [XY_W-1:0] y_next [CORD_STAGES+1][ROT_LANES];
  logic signed [Z_W-1:0] z_next [CORD_STAGES+1][ROT_LANES];
  logic neg_next [CORD_STAGES+1][ROT_LANES];
  logic signed [XY_W-1:0] res_next [ROT_LANES];

  always_comb begin
    logic signed [XY_W-1:0] x, y, dx, dy, o;
    logic signed [Z_W-1:0] z;
    logic ng;
    for (int l = 0; l < ROT_LANES; l++) begin
      z = Z_W'(signed'(ang[l]));
      ng = 1'b0;
      if (z > QUARTER_TURN) begin
        z = z - HALF_TURN;
        ng = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z = z + HALF_TURN;
        ng = 1'b1;
      end
      x_next[0][l] = GAIN_Q30;
      y_next[0][l] = '0;
      z_next[0][l] = z;
      neg_next[0][l] = ng;
    end
    for (int s = 1; s <= CORD_STAGES; s++) begin
      for (int l = 0; l < ROT_LANES; l++) begin
        x = x_r[s-1][l];
        y = y_r[s-1][l];
        z = z_r[s-1][l];
        for (int j = 0; j < CORD_PER_STAGE; j++) begin
          dx = y >>> ((s - 1) * CORD_PER_STAGE + j);
          dy = x >>> ((s - 1) * CORD_PER_STAGE + j);
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turn((s - 1) * CORD_PER_STAGE + j);
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turn((s - 1) * CORD_PER_STAGE + j);
          end
        end
        x_next[s][l] = x;
        y_next[s][l] = y;
        z_next[s][l] = z;
        neg_next[s][l] = neg_r[s-1][l];
      end
    end
    for (int l = 0; l < ROT_LANES; l++) begin
      o = ROT_SIN_LANES[l] ? y_r[CORD_STAGES][l] : x_r[CORD_STAGES][l];
      res_next[l] = neg_r[CORD_STAGES][l] ? -o : o;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[CORD_STAGES:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_next;
      y_r <= y_next;
      z_r <= z_next;
      neg_r <= neg_next;
      res <= res_next;
    end
  end

  assign out_v = v[CORD_STAGES+1];

endmodule

// ----- rtl/hdu_sqrt.sv -----
module hdu_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic [hdu_pkg::A_W-1:0] rad [hdu_pkg::SQ_LANES],
  output logic out_v,
  output logic [hdu_pkg::A_W-1:0] root [hdu_pkg::SQ_LANES]
);
  import hdu_pkg::*;

  logic [SQ_STAGES-1:0] v;
  logic [SQ_N_W-1:0] n_r [SQ_STAGES][SQ_LANES];
  logic [SQ_REM_W-1:0] rem_r [SQ_STAGES][SQ_LANES];
  logic [SQ_STEPS-1:0] root_r [SQ_STAGES][SQ_LANES];
  logic [SQ_N_W-1:0] n_next [SQ_STAGES][SQ_LANES];
  logic [SQ_REM_W-1:0] rem_next [SQ_STAGES][SQ_LANES];
  logic [SQ_STEPS-1:0] root_next [SQ_STAGES][SQ_LANES];

  always_comb begin
    logic [SQ_N_W-1:0] n;
    logic [SQ_REM_W-1:0] rm, trial;
    logic [SQ_STEPS-1:0] rt;
    for (int s = 0; s < SQ_STAGES; s++) begin
      for (int l = 0; l < SQ_LANES; l++) begin
        if (s == 0) begin
          // radicand times 2^30
          n = SQ_N_W'({rad[l], 30'b0});
          rm = '0;
          rt = '0;
        end else begin
          n = n_r[s-1][l];
          rm = rem_r[s-1][l];
          rt = root_r[s-1][l];
        end
        for (int j = 0; j < SQ_PER_STAGE; j++) begin
          rm = {rm[SQ_REM_W-3:0], n[SQ_N_W-1 -: 2]};
          n = {n[SQ_N_W-3:0], 2'b00};
          trial = SQ_REM_W'({rt, 2'b01});
          if (rm >= trial) begin
            rm = rm - trial;
            rt = {rt[SQ_STEPS-2:0], 1'b1};
          end else begin
            rt = {rt[SQ_STEPS-2:0], 1'b0};
          end
        end
        n_next[s][l] = n;
        rem_next[s][l] = rm;
        root_next[s][l] = rt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[SQ_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_next;
      rem_r <= rem_next;
      root_r <= root_next;
    end
  end

  assign out_v = v[SQ_STAGES-1];
  always_comb begin
    for (int l = 0; l < SQ_LANES; l++) begin
      root[l] = root_r[SQ_STAGES-1][l][A_W-1:0];
    end
  end

endmodule

// ----- rtl/hdu_vector.sv -----
module hdu_vector (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  logic [hdu_pkg::A_W-1:0] xin,
  input  logic [hdu_pkg::A_W-1:0] yin,
  output logic out_v,
  output logic [31:0] cturn
);
  import hdu_pkg::*;

  logic [CORD_STAGES:0] v;
  logic signed [Z_W-1:0] x_r [CORD_STAGES];
  logic signed [Z_W-1:0] y_r [CORD_STAGES];
  logic signed [Z_W-1:0] z_r [CORD_STAGES];
  logic signed [Z_W-1:0] x_next [CORD_STAGES];
  logic signed [Z_W-1:0] y_next [CORD_STAGES];
  logic signed [Z_W-1:0] z_next [CORD_STAGES];
  logic [31:0] cturn_next;

  always_comb begin
    logic signed [Z_W-1:0] x, y, z, dx, dy;
    for (int s = 0; s < CORD_STAGES; s++) begin
      if (s == 0) begin
        x = Z_W'(xin);
        y = Z_W'(yin);
        z = '0;
      end else begin
        x = x_r[s-1];
        y = y_r[s-1];
        z = z_r[s-1];
      end
      for (int j = 0; j < CORD_PER_STAGE; j++) begin
        dx = y >>> (s * CORD_PER_STAGE + j);
        dy = x >>> (s * CORD_PER_STAGE + j);
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_turn(s * CORD_PER_STAGE + j);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_turn(s * CORD_PER_STAGE + j);
        end
      end
      x_next[s] = x;
      y_next[s] = y;
      z_next[s] = z;
    end
    // clamp to a quarter turn, then double
    z = z_r[CORD_STAGES-1];
    if (z < 0) begin
      z = '0;
    end else if (z > QUARTER_TURN) begin
      z = QUARTER_TURN;
    end
    cturn_next = {z[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[CORD_STAGES-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_next;
      y_r <= y_next;
      z_r <= z_next;
      cturn <= cturn_next;
    end
  end

  assign out_v = v[CORD_STAGES];

endmodule
